@@ rtl/bole_pkg.sv @@
// Package for the bounded ordered list engine.
// Holds command and status codes and default sizes; no dependencies.
package bole_pkg;
  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W = 5;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_DEL_FRONT = 3'd1,
    CMD_DEL_REAR  = 3'd2,
    CMD_SEARCH    = 3'd3,
    CMD_INS_POS   = 3'd4,
    CMD_DISPLAY   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADPOS = 3'd3,
    ST_NOKEY  = 3'd4
  } status_t;
endpackage

@@ rtl/bounded_ordered_list_engine_unit.sv @@
// Bounded ordered list engine top level: command sequencer around one cell memory.
// Depends on bole_pkg.
// A rejected or ignored command goes straight to its result; an insert that shifts
// nothing writes its cell at once; each element shifted or compared passes through
// read, wait and act; delete rear reads once; display also waits out output stalls.
// One command is in flight; the next item is accepted once the result is taken.
// Reset clears the count and control; cell contents are undefined until written.
module bounded_ordered_list_engine_unit
  import bole_pkg::*;
#(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_cmd,
  input  logic signed [bole_pkg::DATA_W-1:0] in_value,
  input  logic [4:0]                 in_position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic signed [bole_pkg::DATA_W-1:0] out_data,
  output logic [4:0]                 out_count,
  output logic                       out_last
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_WAIT = 6'b000100,
    S_ACT  = 6'b001000,
    S_OUT  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_r;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;

  state_t            state_r, state_nxt;
  logic [HW-1:0]     held_r, held_nxt;
  logic [HW-1:0]     idx_r, idx_nxt;
  logic [HW-1:0]     stop_r, stop_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [2:0]        ost_r, ost_nxt;
  logic [DATA_W-1:0] odata_r, odata_nxt;
  logic              olast_r, olast_nxt;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign in_stall   = (state_r != S_IDLE) || ovalid_r;
  assign out_valid  = ovalid_r;
  assign out_status = ost_r;
  assign out_data   = odata_r;
  assign out_count  = CNT_W'(held_r);
  assign out_last   = olast_r;

  always_comb begin
    state_nxt = state_r; held_nxt = held_r; idx_nxt = idx_r; stop_nxt = stop_r;
    cmd_nxt = cmd_r; val_nxt = val_r;
    ovalid_nxt = ovalid_r && out_stall;
    ost_nxt = ost_r; odata_nxt = odata_r; olast_nxt = olast_r;
    we = 1'b0; waddr = idx_r[AW-1:0]; wdata = val_r; raddr = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd_nxt = cmd_t'(in_cmd);
          val_nxt = in_value;
          ost_nxt = ST_OK; odata_nxt = '0; olast_nxt = 1'b1;
          state_nxt = S_FIN;
          case (in_cmd)
            CMD_INS_FRONT, CMD_INS_POS: begin
              if (held_r >= HW'(CAPACITY)) ost_nxt = ST_FULL;
              else if (in_cmd == CMD_INS_POS && (in_position == 5'd0 ||
                       int'(in_position) > int'(held_r) + 1)) ost_nxt = ST_BADPOS;
              else begin
                stop_nxt = (in_cmd == CMD_INS_POS) ? HW'(in_position - 5'd1) : '0;
                idx_nxt = held_r;
                state_nxt = S_RD;
              end
            end
            CMD_DEL_FRONT, CMD_DEL_REAR, CMD_SEARCH, CMD_DISPLAY: begin
              if (held_r == '0) ost_nxt = ST_EMPTY;
              else begin
                idx_nxt = (in_cmd == CMD_DEL_REAR) ? held_r - HW'(1) : '0;
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if ((cmd_r == CMD_INS_FRONT || cmd_r == CMD_INS_POS) && idx_r == stop_r) begin
          we = 1'b1;
          held_nxt = held_r + HW'(1);
          state_nxt = S_FIN;
        end else begin
          if (cmd_r == CMD_INS_FRONT || cmd_r == CMD_INS_POS)
            raddr = AW'(idx_r - HW'(1));
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (cmd_r == CMD_INS_FRONT || cmd_r == CMD_INS_POS)
          raddr = AW'(idx_r - HW'(1));
        state_nxt = S_ACT;
      end
      S_ACT: begin
        state_nxt = S_RD;
        case (cmd_r)
          CMD_INS_FRONT, CMD_INS_POS: begin
            we = 1'b1; wdata = rdata_r;
            idx_nxt = idx_r - HW'(1);
          end
          CMD_DEL_FRONT: begin
            if (idx_r == '0) odata_nxt = rdata_r;
            else begin
              we = 1'b1; waddr = AW'(idx_r - HW'(1)); wdata = rdata_r;
            end
            idx_nxt = idx_r + HW'(1);
            if (idx_r + HW'(1) == held_r) begin
              held_nxt = held_r - HW'(1); state_nxt = S_FIN;
            end
          end
          CMD_DEL_REAR: begin
            odata_nxt = rdata_r; held_nxt = held_r - HW'(1); state_nxt = S_FIN;
          end
          CMD_SEARCH: begin
            idx_nxt = idx_r + HW'(1);
            if (rdata_r == val_r) begin
              odata_nxt = rdata_r; state_nxt = S_FIN;
            end else if (idx_r + HW'(1) == held_r) begin
              ost_nxt = ST_NOKEY; state_nxt = S_FIN;
            end
          end
          default: begin
            if (ovalid_r) state_nxt = S_ACT;
            else begin
              odata_nxt = rdata_r;
              olast_nxt = (idx_r + HW'(1) == held_r);
              idx_nxt = idx_r + HW'(1);
              state_nxt = S_OUT;
            end
          end
        endcase
      end
      S_OUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          state_nxt = olast_r ? S_IDLE : S_RD;
        end
      end
      S_FIN: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; held_r <= '0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; held_r <= held_nxt; ovalid_r <= ovalid_nxt;
    end
    idx_r <= idx_nxt; stop_r <= stop_nxt; cmd_r <= cmd_nxt; val_r <= val_nxt;
    ost_r <= ost_nxt; odata_r <= odata_nxt; olast_r <= olast_nxt;
  end

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HW'(CAPACITY)) else $error("count exceeds capacity");
  a_held_step: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != $past(held_r)) |-> (held_r == $past(held_r) + HW'(1) ||
      held_r == $past(held_r) - HW'(1))) else $error("count jumped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
endmodule

@@ tb/bounded_ordered_list_engine_unit_tb.sv @@
// Testbench for bounded_ordered_list_engine_unit: directed and random list commands,
// checked against an in-bench list predictor. Depends on bole_pkg and the RTL top.
`timescale 1ns / 100ps

module bounded_ordered_list_engine_unit_tb;
  import bole_pkg::*;

  localparam int CAP = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [4:0]  position;
  } list_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data;
    logic [4:0]  count;
    logic        last;
  } list_resp_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_cmd;
  logic signed [31:0] in_value;
  logic [4:0] in_position;
  logic out_valid;
  logic out_stall;
  logic [2:0] out_status;
  logic signed [31:0] out_data;
  logic [4:0] out_count;
  logic out_last;

  list_cmd_t  pending_cmds[$];
  list_resp_t expected_resps[$];
  logic [31:0] model_cells[CAP];
  int model_held;
  int mismatches;
  int resp_seen;
  int cmds_sent;
  int cycle_count;
  bit quiet_window;
  bit stim_done;

  bounded_ordered_list_engine_unit #(.CAPACITY(CAP)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_value(in_value), .in_position(in_position),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_data(out_data), .out_count(out_count), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic list_resp_t make_resp(logic [2:0] st, logic [31:0] d, bit fin);
    list_resp_t r;
    r.status = st;
    r.data = d;
    r.count = model_held[4:0];
    r.last = fin;
    return r;
  endfunction

  task automatic predict_list_cmd(list_cmd_t c);
    int i;
    int p;
    bit hit;
    logic [31:0] d;
    hit = 1'b0;
    case (c.cmd)
      CMD_INS_FRONT, CMD_INS_POS: begin
        p = (c.cmd == CMD_INS_FRONT) ? 1 : int'(c.position);
        if (model_held >= CAP) begin
          expected_resps.push_back(make_resp(ST_FULL, '0, 1'b1));
        end else if (p < 1 || p > model_held + 1) begin
          expected_resps.push_back(make_resp(ST_BADPOS, '0, 1'b1));
        end else begin
          for (i = model_held; i > p - 1; i--) model_cells[i] = model_cells[i-1];
          model_cells[p-1] = c.value;
          model_held++;
          expected_resps.push_back(make_resp(ST_OK, '0, 1'b1));
        end
      end
      CMD_DEL_FRONT, CMD_DEL_REAR, CMD_SEARCH, CMD_DISPLAY: begin
        if (model_held == 0) begin
          expected_resps.push_back(make_resp(ST_EMPTY, '0, 1'b1));
        end else if (c.cmd == CMD_DEL_FRONT) begin
          d = model_cells[0];
          for (i = 1; i < model_held; i++) model_cells[i-1] = model_cells[i];
          model_held--;
          expected_resps.push_back(make_resp(ST_OK, d, 1'b1));
        end else if (c.cmd == CMD_DEL_REAR) begin
          model_held--;
          expected_resps.push_back(make_resp(ST_OK, model_cells[model_held], 1'b1));
        end else if (c.cmd == CMD_SEARCH) begin
          for (i = 0; i < model_held; i++) begin
            if (!hit && model_cells[i] == c.value) hit = 1'b1;
          end
          expected_resps.push_back(hit ? make_resp(ST_OK, c.value, 1'b1)
                                       : make_resp(ST_NOKEY, '0, 1'b1));
        end else begin
          for (i = 0; i < model_held; i++)
            expected_resps.push_back(make_resp(ST_OK, model_cells[i], i + 1 == model_held));
        end
      end
      default: expected_resps.push_back(make_resp(ST_OK, '0, 1'b1));
    endcase
  endtask

  function automatic list_cmd_t mk(logic [2:0] op, logic [31:0] v, logic [4:0] p);
    list_cmd_t c;
    c.cmd = op;
    c.value = v;
    c.position = p;
    return c;
  endfunction

  // Stimulus: directed corners, then random mix weighted toward inserts and searches
  initial begin
    int n;
    logic [2:0] op;
    logic [31:0] v;
    logic [31:0] recent[$];
    pending_cmds.push_back(mk(CMD_DEL_FRONT, '0, '0));
    pending_cmds.push_back(mk(CMD_DEL_REAR, '0, '0));
    pending_cmds.push_back(mk(CMD_SEARCH, 32'h1, '0));
    pending_cmds.push_back(mk(CMD_DISPLAY, '0, '0));
    pending_cmds.push_back(mk(CMD_INS_POS, 32'h5, 5'd0));
    pending_cmds.push_back(mk(CMD_INS_POS, 32'h5, 5'd2));
    pending_cmds.push_back(mk(CMD_INS_FRONT, 32'h8000_0000, '0));
    pending_cmds.push_back(mk(CMD_INS_POS, 32'h7FFF_FFFF, 5'd2));
    pending_cmds.push_back(mk(CMD_INS_POS, 32'hFFFF_FFFF, 5'd1));
    pending_cmds.push_back(mk(CMD_INS_POS, 32'h0, 5'd31));
    pending_cmds.push_back(mk(CMD_SEARCH, 32'h7FFF_FFFF, '0));
    pending_cmds.push_back(mk(CMD_SEARCH, 32'h1234_5678, '0));
    pending_cmds.push_back(mk(CMD_DISPLAY, '0, '0));
    pending_cmds.push_back(mk(3'd6, 32'hFFFF_FFFF, 5'd31));
    pending_cmds.push_back(mk(3'd7, '0, '0));
    for (n = 0; n < 14; n++) pending_cmds.push_back(mk(CMD_INS_FRONT, $urandom, '0));
    pending_cmds.push_back(mk(CMD_INS_FRONT, 32'h1, '0));
    pending_cmds.push_back(mk(CMD_INS_POS, 32'h1, 5'd3));
    pending_cmds.push_back(mk(CMD_INS_POS, 32'h1, 5'd0));
    pending_cmds.push_back(mk(CMD_DISPLAY, '0, '0));
    for (n = 0; n < 16; n++) pending_cmds.push_back(mk(CMD_DEL_REAR, '0, '0));
    for (n = 0; n < 100; n++) begin
      case ($urandom_range(0, 99)) inside
        [0:24]:  op = CMD_INS_FRONT;
        [25:49]: op = CMD_INS_POS;
        [50:59]: op = CMD_DEL_FRONT;
        [60:69]: op = CMD_DEL_REAR;
        [70:84]: op = CMD_SEARCH;
        [85:94]: op = CMD_DISPLAY;
        default: op = 3'($urandom_range(6, 7));
      endcase
      v = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : 32'($urandom);
      if (op == CMD_SEARCH && recent.size() > 0 && $urandom_range(0, 1))
        v = recent[$urandom_range(0, recent.size() - 1)];
      if (op == CMD_INS_FRONT || op == CMD_INS_POS) recent.push_back(v);
      pending_cmds.push_back(mk(op, v, ($urandom_range(0, 9) == 0) ? 5'($urandom)
                                          : 5'($urandom_range(1, 17))));
    end
    stim_done = 1'b1;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_value = '0;
    in_position = '0;
    out_stall = 1'b0;
    mismatches = 0;
    resp_seen = 0;
    cmds_sent = 0;
    cycle_count = 0;
    model_held = 0;
    quiet_window = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      quiet_window <= (cycle_count % 3000) > 2000;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_list_cmd({in_cmd, in_value, in_position});
        cmds_sent <= cmds_sent + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_cmds.size() > 0 && (quiet_window || $urandom_range(0, 99) >= 26)) begin
          list_cmd_t c;
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_cmd <= c.cmd;
          in_value <= c.value;
          in_position <= c.position;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= !quiet_window && ($urandom_range(0, 99) < 26);
      if (out_valid && !out_stall) begin
        list_resp_t want;
        resp_seen <= resp_seen + 1;
        if (expected_resps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: status %0d data %h", out_status,
                                         out_data);
        end else begin
          want = expected_resps.pop_front();
          if (want.status !== out_status || want.data !== out_data ||
              want.count !== out_count || want.last !== out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp st %0d d %h cnt %0d last %0d, ",
                        "got st %0d d %h cnt %0d last %0d"},
                       want.status, want.data, want.count, want.last,
                       out_status, out_data, out_count, out_last);
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done && rst_n);
    while ((pending_cmds.size() > 0 || in_valid || expected_resps.size() > 0)
           && cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      repeat (100) @(posedge clk);
      $display("sent %0d list commands, checked %0d results, %0d mismatches",
               cmds_sent, resp_seen, mismatches);
      if (mismatches == 0 && expected_resps.size() == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
      $finish;
    end
  end
endmodule

@@ filelist.f @@
rtl/bole_pkg.sv
rtl/bounded_ordered_list_engine_unit.sv
tb/bounded_ordered_list_engine_unit_tb.sv
